// ===== rtl/qat_pkg.sv =====
// Shared types and character codes for the quoted argument tokenizer.
`timescale 1ns / 1ps

package qat_pkg;

    // Character codes with special meaning
    localparam logic [7:0] CH_TAB    = 8'd9;
    localparam logic [7:0] CH_LF     = 8'd10;
    localparam logic [7:0] CH_CR     = 8'd13;
    localparam logic [7:0] CH_SPACE  = 8'd32;
    localparam logic [7:0] CH_DQUOTE = 8'd34;
    localparam logic [7:0] CH_HASH   = 8'd35;
    localparam logic [7:0] CH_SQUOTE = 8'd39;
    localparam logic [7:0] CH_LPAREN = 8'd40;
    localparam logic [7:0] CH_RPAREN = 8'd41;
    localparam logic [7:0] CH_COMMA  = 8'd44;
    localparam logic [7:0] CH_LBRACE = 8'd123;
    localparam logic [7:0] CH_RBRACE = 8'd125;

    // Quoting kinds
    localparam logic [1:0] Q_NONE   = 2'd0;
    localparam logic [1:0] Q_DOUBLE = 2'd1;
    localparam logic [1:0] Q_SINGLE = 2'd2;
    localparam logic [1:0] Q_BRACE  = 2'd3;

    // Configuration register indexes
    localparam int unsigned CFG_IDX_W = 4;
    localparam logic [CFG_IDX_W-1:0] CFG_USE_QUOTES     = 4'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_USE_CURLIES    = 4'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_STRIP_BRACKETS = 4'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_COMMA_IS_PLAIN = 4'd3;

    typedef struct packed {
        logic use_quotes;
        logic use_curlies;
        logic strip_brackets;
        logic comma_is_plain;
    } t_cfg;

    typedef struct packed {
        logic [1:0] quote_kind;
        logic       token_has_chars;
        logic       line_over;
    } t_state;

    typedef struct packed {
        logic       append_valid;
        logic [7:0] append_char;
        logic       token_end;
        logic       token_kept;
        logic       line_end;
    } t_result;

    localparam t_state STATE_CLEAR = '{quote_kind: Q_NONE, token_has_chars: 1'b0,
                                       line_over: 1'b0};

endpackage

// ===== rtl/qat_step.sv =====
// Per-character decode and line state update of the tokenizer.
`timescale 1ns / 1ps

module qat_step (
    input  qat_pkg::t_cfg    i_cfg,
    input  qat_pkg::t_state  i_state,
    input  logic [7:0]       i_character,
    input  logic             i_last_in_line,
    output qat_pkg::t_state  o_state,
    output qat_pkg::t_result o_result
);

    always_comb begin
        qat_pkg::t_state nxt;
        logic            app;
        logic            tok_end;
        logic            by_quote;
        logic            eol;
        logic            kept;
        logic [1:0]      kind;

        nxt      = i_state;
        app      = 1'b0;
        tok_end  = 1'b0;
        by_quote = 1'b0;
        eol      = 1'b0;
        kept     = 1'b0;
        kind     = (i_character == qat_pkg::CH_DQUOTE) ? qat_pkg::Q_DOUBLE
                                                       : qat_pkg::Q_SINGLE;

        if (i_state.line_over) begin
            // Skip the rest of the line, report only line end
            eol = 1'b1;
            if (i_last_in_line) begin
                nxt = qat_pkg::STATE_CLEAR;
            end
        end else begin
            case (i_character)
                qat_pkg::CH_LF, qat_pkg::CH_CR, qat_pkg::CH_HASH: begin
                    tok_end = 1'b1;
                    eol     = 1'b1;
                end
                qat_pkg::CH_COMMA: begin
                    if (i_cfg.comma_is_plain || i_state.quote_kind != qat_pkg::Q_NONE) begin
                        app = 1'b1;
                    end else if (i_state.token_has_chars) begin
                        tok_end = 1'b1;
                    end
                end
                qat_pkg::CH_TAB, qat_pkg::CH_SPACE: begin
                    if (i_state.quote_kind != qat_pkg::Q_NONE) begin
                        app = 1'b1;
                    end else if (i_state.token_has_chars) begin
                        tok_end = 1'b1;
                    end
                end
                qat_pkg::CH_DQUOTE, qat_pkg::CH_SQUOTE: begin
                    if (i_cfg.use_quotes) begin
                        if (i_state.quote_kind == qat_pkg::Q_NONE) begin
                            nxt.quote_kind = kind;
                        end else if (i_state.quote_kind == kind) begin
                            nxt.quote_kind = qat_pkg::Q_NONE;
                            by_quote       = 1'b1;
                            tok_end        = 1'b1;
                        end else begin
                            app = 1'b1;
                        end
                    end
                end
                qat_pkg::CH_LBRACE, qat_pkg::CH_RBRACE: begin
                    if (!i_cfg.use_curlies) begin
                        app = 1'b1;
                    end else if (i_state.quote_kind == qat_pkg::Q_BRACE &&
                                 i_character == qat_pkg::CH_RBRACE) begin
                        nxt.quote_kind = qat_pkg::Q_NONE;
                    end else begin
                        if (i_state.quote_kind != qat_pkg::Q_NONE) begin
                            app = 1'b1;
                        end
                        if (i_character == qat_pkg::CH_LBRACE) begin
                            nxt.quote_kind = qat_pkg::Q_BRACE;
                        end
                    end
                end
                qat_pkg::CH_LPAREN, qat_pkg::CH_RPAREN: begin
                    app = !i_cfg.strip_brackets;
                end
                default: begin
                    app = 1'b1;
                end
            endcase

            if (app) begin
                nxt.token_has_chars = 1'b1;
            end
            if (i_last_in_line) begin
                tok_end = 1'b1;
                eol     = 1'b1;
            end
            if (tok_end) begin
                kept                = nxt.token_has_chars || by_quote;
                nxt.quote_kind      = qat_pkg::Q_NONE;
                nxt.token_has_chars = 1'b0;
            end
            if (eol) begin
                if (i_last_in_line) begin
                    nxt = qat_pkg::STATE_CLEAR;
                end else begin
                    nxt.line_over = 1'b1;
                end
            end
        end

        o_state               = nxt;
        o_result.append_valid = app;
        o_result.append_char  = app ? i_character : 8'd0;
        o_result.token_end    = tok_end;
        o_result.token_kept   = kept;
        o_result.line_end     = eol;
    end

endmodule

// ===== rtl/quoted_argument_tokenizer_unit.sv =====
// Top level of the quoted argument tokenizer: request registers and line state.
`timescale 1ns / 1ps

// Quoted argument tokenizer. Feed one character per request with a flag on
// the final character of the line; each request yields exactly one result
// that says whether the character joins the current argument, whether the
// argument closes (and is kept), and whether the line is over. Throughput
// is one character per clock while the result is not stalled: the input
// register holds the request, and the result register captures its decode
// once the result slot is free, with combinational decode logic between
// the two registers. A stalled result holds the request in the
// input register, and a new request is taken in the same cycle that the
// held one moves on. The line state (quote kind, argument nonempty, line
// over) lives in flip-flops that update when a request moves from the input
// register to the result register. Write the four one-bit configuration
// registers (index 0 use quotes, 1 use curlies, 2 strip brackets, 3 comma is
// plain; only data bit 0 is used, other indexes are ignored) only while no
// request is in flight.
module quoted_argument_tokenizer_unit (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // configuration write port
    input  logic                          i_cfg_we,
    input  logic [qat_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic                          i_cfg_data,
    // character requests
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  logic [7:0]                    i_character,
    input  logic                          i_last_in_line,
    // results
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output logic                          o_append_valid,
    output logic [7:0]                    o_append_char,
    output logic                          o_token_end,
    output logic                          o_token_kept,
    output logic                          o_line_end
);

    qat_pkg::t_cfg    r_cfg;
    qat_pkg::t_state  r_state;
    qat_pkg::t_state  n_state;
    qat_pkg::t_result n_result;
    qat_pkg::t_result r_result;

    logic       r_in_valid;
    logic [7:0] r_character;
    logic       r_last;
    logic       r_out_valid;

    logic out_free;   // result register can take a new result this cycle
    logic in_load;    // input register takes a new request
    logic advance;    // held request is decoded into the result register

    assign out_free   = !r_out_valid || !i_out_stall;
    assign advance    = r_in_valid && out_free;
    // Input register frees up when its request moves on this cycle.
    assign o_in_stall = r_in_valid && !out_free;
    assign in_load    = i_in_valid && !o_in_stall;

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                qat_pkg::CFG_USE_QUOTES:     r_cfg.use_quotes     <= i_cfg_data;
                qat_pkg::CFG_USE_CURLIES:    r_cfg.use_curlies    <= i_cfg_data;
                qat_pkg::CFG_STRIP_BRACKETS: r_cfg.strip_brackets <= i_cfg_data;
                qat_pkg::CFG_COMMA_IS_PLAIN: r_cfg.comma_is_plain <= i_cfg_data;
                default: begin
                    // drop writes to unknown indexes
                end
            endcase
        end
    end

    // Input register: hold the request until the result slot is free
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_load) begin
            r_in_valid <= 1'b1;
        end else if (advance) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_load) begin
            r_character <= i_character;
            r_last      <= i_last_in_line;
        end
    end

    // Decode the held character against the current line state
    qat_step u_step (
        .i_cfg          (r_cfg),
        .i_state        (r_state),
        .i_character    (r_character),
        .i_last_in_line (r_last),
        .o_state        (n_state),
        .o_result       (n_result)
    );

    // Line state advances only as each request is decoded
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= qat_pkg::STATE_CLEAR;
        end else if (advance) begin
            r_state <= n_state;
        end
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_free) begin
            r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_result <= n_result;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_append_valid = r_result.append_valid;
    assign o_append_char  = r_result.append_char;
    assign o_token_end    = r_result.token_end;
    assign o_token_kept   = r_result.token_kept;
    assign o_line_end     = r_result.line_end;

endmodule
